// ===== hdl/binco_pkg.sv =====
// Shared constants, status codes and sequencer state type for the binomial coefficient core.
package binco_pkg;

    localparam int N_WIDTH      = 7;
    localparam int RESULT_WIDTH = 32;
    localparam int PROD_WIDTH   = RESULT_WIDTH + N_WIDTH;
    localparam int CNT_WIDTH    = $clog2(PROD_WIDTH + 1);

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_K_GT_N   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [PROD_WIDTH-1:0] dividend;
        logic [N_WIDTH-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [PROD_WIDTH-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hdl/binomial_coefficient_core.sv =====
// Exact binomial coefficient C(n,k) via multiply and bit-serial exact divide steps.
// When k > n or min(k, n-k) = 0 the result is valid in the cycle after accept; otherwise
// min(k, n-k) steps run, each a multiply, a divider load, the divider's bit shifts and done.
// At most 17 steps run (C(35,17) overflows, so any longer loop stops there); overflow ends the loop.
// One item at a time: the next item is accepted the cycle after the result is taken. Reset
// (synchronous, active low) returns the sequencer to idle and drops any item in progress.
module binomial_coefficient_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [binco_pkg::N_WIDTH-1:0]     i_n,
    input  logic [binco_pkg::N_WIDTH-1:0]     i_k,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [binco_pkg::RESULT_WIDTH-1:0] o_coefficient,
    output logic [1:0]                        o_status
);
    import binco_pkg::*;

    t_state r_state, n_state;

    logic [N_WIDTH-1:0]      r_n, n_n;
    logic [N_WIDTH-1:0]      r_t, n_t;
    logic [N_WIDTH-1:0]      r_i, n_i;
    logic [RESULT_WIDTH-1:0] r_r, n_r;
    logic [PROD_WIDTH-1:0]   r_prod, n_prod;
    logic [RESULT_WIDTH-1:0] r_coef, n_coef;
    logic [1:0]              r_status, n_status;

    logic               accept;
    logic [N_WIDTH-1:0] n_minus_k;
    logic [N_WIDTH-1:0] t_in;
    logic [N_WIDTH-1:0] factor;
    logic               quot_over;

    t_div_req div_req;
    t_div_rsp div_rsp;

    binco_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign accept    = i_valid && !o_stall;
    assign n_minus_k = i_n - i_k;
    assign t_in      = (i_k > n_minus_k) ? n_minus_k : i_k;
    assign factor    = r_n - r_t + r_i;
    assign quot_over = |div_rsp.quotient[PROD_WIDTH-1:RESULT_WIDTH];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_k > i_n || t_in == '0) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL:  n_state = S_LOAD;
            S_LOAD: n_state = S_DIV;
            S_DIV: begin
                if (div_rsp.done) begin
                    if (quot_over || r_i == r_t) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_n      = r_n;
        n_t      = r_t;
        n_i      = r_i;
        n_r      = r_r;
        n_prod   = r_prod;
        n_coef   = r_coef;
        n_status = r_status;
        div_req.start    = 1'b0;
        div_req.dividend = r_prod;
        div_req.divisor  = r_i;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_n = i_n;
                    n_t = t_in;
                    n_i = N_WIDTH'(1);
                    n_r = RESULT_WIDTH'(1);
                    if (i_k > i_n) begin
                        n_coef   = '0;
                        n_status = STATUS_K_GT_N;
                    end else begin
                        n_coef   = RESULT_WIDTH'(1);
                        n_status = STATUS_OK;
                    end
                end
            end
            S_MUL: begin
                n_prod = {{N_WIDTH{1'b0}}, r_r} * {{RESULT_WIDTH{1'b0}}, factor};
            end
            S_LOAD: begin
                div_req.start = 1'b1;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (quot_over) begin
                        n_coef   = '1;
                        n_status = STATUS_OVERFLOW;
                    end else begin
                        n_r      = div_rsp.quotient[RESULT_WIDTH-1:0];
                        n_i      = r_i + 1'b1;
                        n_coef   = div_rsp.quotient[RESULT_WIDTH-1:0];
                        n_status = STATUS_OK;
                    end
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_t      <= n_t;
        r_i      <= n_i;
        r_r      <= n_r;
        r_prod   <= n_prod;
        r_coef   <= n_coef;
        r_status <= n_status;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_coefficient = r_coef;
    assign o_status      = r_status;

endmodule

// ===== hdl/binco_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module binco_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  binco_pkg::t_div_req i_req,
    output binco_pkg::t_div_rsp o_rsp
);
    import binco_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_WIDTH-1:0]  r_cnt;
    logic [PROD_WIDTH-1:0] r_q;
    logic [N_WIDTH-1:0]    r_rem;
    logic [N_WIDTH-1:0]    r_div;

    logic [N_WIDTH:0]      rem_sh;
    logic [N_WIDTH+1:0]    diff;
    logic                  q_bit;
    logic [N_WIDTH-1:0]    n_rem;

    always_comb begin
        rem_sh = {r_rem, r_q[PROD_WIDTH-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_div};
        q_bit  = ~diff[N_WIDTH+1];
        n_rem  = q_bit ? diff[N_WIDTH-1:0] : rem_sh[N_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_WIDTH'(PROD_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[PROD_WIDTH-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for binomial_coefficient_core: directed table, random items, watchdog.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import binco_pkg::*;

    localparam int RANDOM_ITEMS   = 206;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] coef;
        logic [1:0]              status;
    } t_binom;

    typedef struct packed {
        logic [N_WIDTH-1:0] n;
        logic [N_WIDTH-1:0] k;
        logic               known;
        t_binom             res;
    } t_stim_row;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic [N_WIDTH-1:0]      i_n     = '0;
    logic [N_WIDTH-1:0]      i_k     = '0;
    logic                    i_stall = 1'b0;
    logic                    o_stall;
    logic                    o_valid;
    logic [RESULT_WIDTH-1:0] o_coefficient;
    logic [1:0]              o_status;

    t_binom    coef_q[$];
    t_stim_row dir_rows[$];
    t_binom    exp_res;
    int        err_cnt      = 0;
    int        stuck_cycles = 0;
    bit        idle_en      = 1'b1;

    binomial_coefficient_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_n           (i_n),
        .i_k           (i_k),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coefficient (o_coefficient),
        .o_status      (o_status)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= idle_en && ($urandom_range(0, 99) < 11);
    end

    // exact C(n,k) by the multiplicative formula, saturating past RESULT_WIDTH bits
    function automatic t_binom calc_binom(input logic [N_WIDTH-1:0] n,
                                          input logic [N_WIDTH-1:0] k);
        t_binom          r;
        longint unsigned acc;
        int              steps;
        int              i;
        r.coef   = '0;
        r.status = STATUS_OK;
        acc      = 1;
        if (k > n) begin
            r.status = STATUS_K_GT_N;
            return r;
        end
        steps = (int'(k) > int'(n) - int'(k)) ? int'(n) - int'(k) : int'(k);
        for (i = 1; i <= steps && r.status == STATUS_OK; i++) begin
            acc = acc * longint'(int'(n) - steps + i) / longint'(i);
            if (acc > {RESULT_WIDTH{1'b1}})
                r.status = STATUS_OVERFLOW;
        end
        r.coef = (r.status == STATUS_OVERFLOW) ? '1 : acc[RESULT_WIDTH-1:0];
        return r;
    endfunction

    task automatic add_row(input int n, input int k, input logic known,
                           input logic [RESULT_WIDTH-1:0] c, input logic [1:0] s);
        dir_rows.push_back({N_WIDTH'(n), N_WIDTH'(k), known, c, s});
    endtask

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic drive_item(input logic [N_WIDTH-1:0] n, input logic [N_WIDTH-1:0] k,
                              input t_binom res);
        while (idle_en && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            i_n     <= N_WIDTH'($urandom);
            i_k     <= N_WIDTH'($urandom);
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_n     <= n;
        i_k     <= k;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        coef_q.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        while (coef_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (coef_q.size() == 0) begin
                $error("result with no item pending: coefficient %0d status %0d",
                       o_coefficient, o_status);
                err_cnt++;
            end else begin
                exp_res = coef_q.pop_front();
                if (o_coefficient !== exp_res.coef) begin
                    $error("coefficient: expected %0d, got %0d", exp_res.coef, o_coefficient);
                    err_cnt++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin : watchdog
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_stim_row          row;
        logic [N_WIDTH-1:0] n;
        logic [N_WIDTH-1:0] k;
        int                 sel;
        int                 j;

        add_row(0,   0,   1'b1, 1,   STATUS_OK);
        add_row(1,   0,   1'b1, 1,   STATUS_OK);
        add_row(1,   1,   1'b1, 1,   STATUS_OK);
        add_row(127, 0,   1'b1, 1,   STATUS_OK);
        add_row(127, 127, 1'b1, 1,   STATUS_OK);
        add_row(127, 1,   1'b1, 127, STATUS_OK);
        add_row(127, 126, 1'b1, 127, STATUS_OK);
        add_row(0,   1,   1'b1, 0,   STATUS_K_GT_N);
        add_row(0,   127, 1'b1, 0,   STATUS_K_GT_N);
        add_row(126, 127, 1'b1, 0,   STATUS_K_GT_N);
        add_row(42,  85,  1'b1, 0,   STATUS_K_GT_N);
        add_row(127, 63,  1'b1, '1,  STATUS_OVERFLOW);
        add_row(127, 64,  1'b1, '1,  STATUS_OVERFLOW);
        add_row(2,   1,   1'b0, '0,  STATUS_OK);
        add_row(10,  5,   1'b0, '0,  STATUS_OK);
        add_row(33,  16,  1'b0, '0,  STATUS_OK);
        add_row(34,  17,  1'b0, '0,  STATUS_OK);
        add_row(35,  16,  1'b0, '0,  STATUS_OK);
        add_row(35,  17,  1'b0, '0,  STATUS_OK);
        add_row(36,  16,  1'b0, '0,  STATUS_OK);
        add_row(64,  32,  1'b0, '0,  STATUS_OK);
        add_row(85,  42,  1'b0, '0,  STATUS_OK);
        add_row(127, 2,   1'b0, '0,  STATUS_OK);
        add_row(127, 5,   1'b0, '0,  STATUS_OK);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (j = 0; j < dir_rows.size(); j++) begin
            row = dir_rows[j];
            drive_item(row.n, row.k, row.known ? row.res : calc_binom(row.n, row.k));
        end

        hold_until_drained();

        for (j = 0; j < RANDOM_ITEMS; j++) begin
            idle_en = !(j >= 60 && j < 120);
            if (j == 150)
                hold_until_drained();
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                n = N_WIDTH'($urandom);
                k = N_WIDTH'($urandom);
            end else if (sel < 20) begin
                n = N_WIDTH'($urandom_range(0, 126));
                k = N_WIDTH'($urandom_range(n + 1, 127));
            end else begin
                n = (sel < 40) ? N_WIDTH'($urandom_range(0, 127)) : N_WIDTH'($urandom_range(0, 40));
                k = N_WIDTH'($urandom_range(0, n));
            end
            drive_item(n, k, calc_binom(n, k));
        end

        idle_en = 1'b1;
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/binco_pkg.sv
hdl/binco_div.sv
hdl/binomial_coefficient_core.sv
verif/tb_top.sv
